// File: rtl/core/fchc_pkg.sv
`default_nettype none

package fchc_pkg;

  localparam int TEMP_W      = 8;
  localparam int PCT_W       = 7;
  localparam int NUM_POINTS  = 8;
  localparam int SEG_W       = $clog2(NUM_POINTS);
  localparam int STEP_CNT_W  = 4;
  localparam int HYST_W      = 7;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int POINT_W     = 16;

  // Serial datapath widths: |p1 - p0| times (t - t0), divided by (t1 - t0).
  localparam int MCAND_W     = PCT_W;
  localparam int MPLIER_W    = TEMP_W;
  localparam int PROD_W      = MCAND_W + MPLIER_W;
  localparam int QUOT_W      = PCT_W;
  localparam int MUL_CNT_W   = $clog2(MPLIER_W);
  localparam int DIV_CNT_W   = $clog2(QUOT_W);

  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEPS_LOW   = 3'd0,
    REG_STEPS_HIGH  = 3'd1,
    REG_STEP_COUNT  = 3'd2,
    REG_HYSTERESIS  = 3'd3,
    REG_START_POWER = 3'd4,
    REG_ZERO_FAN    = 3'd5
  } cfg_reg_t;

  // Handshake between the sequencer and a serial arithmetic unit.
  typedef struct packed {
    logic start;
  } unit_cmd_t;

  typedef struct packed {
    logic done;
  } unit_sts_t;

  function automatic logic [PCT_W-1:0] sat_pct(input logic [7:0] raw);
    if (raw > {1'b0, PCT_MAX}) begin
      return PCT_MAX;
    end
    return raw[PCT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/fchc_if.sv
`default_nettype none

interface fchc_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fchc_pkg::TEMP_W-1:0]   temperature;
  logic                                 fan_stopped;

  modport source(output valid, temperature, fan_stopped, input ready);
  modport sink(input valid, temperature, fan_stopped, output ready);
endinterface

interface fchc_result_if;
  logic                        valid;
  logic                        ready;
  logic                        apply;
  logic [fchc_pkg::PCT_W-1:0]  power;
  logic                        kick;

  modport source(output valid, apply, power, kick, input ready);
  modport sink(input valid, apply, power, kick, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fchc_mul.sv
`default_nettype none

module fchc_mul (
  input  wire                                 clk,
  input  wire                                 rst,
  input  fchc_pkg::unit_cmd_t                 cmd,
  input  wire [fchc_pkg::MCAND_W-1:0]         mcand,
  input  wire [fchc_pkg::MPLIER_W-1:0]        mplier,
  output fchc_pkg::unit_sts_t                 sts,
  output logic [fchc_pkg::PROD_W-1:0]         product
);

  logic                                active;
  logic                                done;
  logic [fchc_pkg::MUL_CNT_W-1:0]      cnt;
  logic [fchc_pkg::PROD_W-1:0]         mc;
  logic [fchc_pkg::MPLIER_W-1:0]       mp;

  // One multiplier bit per cycle, least significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        active  <= 1'b1;
        cnt     <= '0;
        product <= '0;
        mc      <= fchc_pkg::PROD_W'(mcand);
        mp      <= mplier;
      end else if (active) begin
        if (mp[0]) begin
          product <= product + mc;
        end
        mc  <= {mc[fchc_pkg::PROD_W-2:0], 1'b0};
        mp  <= {1'b0, mp[fchc_pkg::MPLIER_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == fchc_pkg::MUL_CNT_W'(fchc_pkg::MPLIER_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign sts.done = done;

endmodule

`default_nettype wire

// File: rtl/core/fchc_div.sv
`default_nettype none

module fchc_div (
  input  wire                                 clk,
  input  wire                                 rst,
  input  fchc_pkg::unit_cmd_t                 cmd,
  input  wire [fchc_pkg::PROD_W-1:0]          dividend,
  input  wire [fchc_pkg::MPLIER_W-1:0]        divisor,
  output fchc_pkg::unit_sts_t                 sts,
  output logic [fchc_pkg::QUOT_W-1:0]         quotient
);

  logic                                active;
  logic                                done;
  logic [fchc_pkg::DIV_CNT_W-1:0]      cnt;
  logic [fchc_pkg::PROD_W-1:0]         rem;
  logic [fchc_pkg::PROD_W-1:0]         dsh;
  logic                                fits;

  // The quotient is known to fit in QUOT_W bits, so the divisor starts
  // aligned to the top quotient bit and moves right one place per cycle.
  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        active   <= 1'b1;
        cnt      <= '0;
        rem      <= dividend;
        dsh      <= fchc_pkg::PROD_W'({divisor, {(fchc_pkg::QUOT_W - 1){1'b0}}});
        quotient <= '0;
      end else if (active) begin
        if (fits) begin
          rem <= rem - dsh;
        end
        quotient <= {quotient[fchc_pkg::QUOT_W-2:0], fits};
        dsh      <= {1'b0, dsh[fchc_pkg::PROD_W-1:1]};
        cnt      <= cnt + 1'b1;
        if (cnt == fchc_pkg::DIV_CNT_W'(fchc_pkg::QUOT_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign sts.done = done;

endmodule

`default_nettype wire

// File: rtl/core/fan_curve_hysteresis_controller.sv
// Fan curve controller with hysteresis.
// The sample channel carries one temperature and a fan-stopped flag per
// transaction; the result channel returns exactly one transaction for each
// sample: apply, power and kick. Both channels use valid/ready handshakes.
// The curve, step count, hysteresis, start power and zero-fan mode are set
// through the write port (cfg_we, cfg_index, cfg_data). The user must write
// them only while the block is idle; the block itself does not enforce this.
// A sample that needs no interpolation goes from setup straight to the finish
// state, which loads the output register. An interpolated point first goes
// through the multiply and divide states: a bit-serial multiplier runs 8 steps
// and a restoring divider 7 steps, with sequencing states around them.
// One sample is processed at a time; the sample channel is ready again as
// soon as the previous result sits in the output register, even if the
// receiver has not taken it yet. A stalled receiver holds the result register
// and, once the next result is complete, holds the sequencer as well.
// Reset restores the default curve registers, forgets the last applied
// temperature so that the next sample always applies, and empties the
// output register.
`default_nettype none

module fan_curve_hysteresis_controller (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire [fchc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [fchc_pkg::CFG_DATA_W-1:0]      cfg_data,
  fchc_sample_if.sink                         sample,
  fchc_result_if.source                       result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

  localparam int TW = fchc_pkg::TEMP_W;
  localparam int PW = fchc_pkg::PCT_W;
  localparam int NP = fchc_pkg::NUM_POINTS;
  localparam int SW = fchc_pkg::SEG_W;
  localparam int CW = fchc_pkg::STEP_CNT_W;
  localparam int BW = TW + 2;

  state_t state;

  logic [fchc_pkg::CFG_DATA_W-1:0]  steps_low;
  logic [fchc_pkg::CFG_DATA_W-1:0]  steps_high;
  logic [CW-1:0]                    step_count;
  logic [fchc_pkg::HYST_W-1:0]      hysteresis;
  logic [PW-1:0]                    start_power;
  logic                             zero_fan_allowed;

  logic signed [TW-1:0]             last_temp;
  logic                             have_last;

  logic signed [TW-1:0]             samp_temp;
  logic                             samp_stopped;

  logic [PW-1:0]                    base;
  logic                             neg;
  logic [fchc_pkg::MCAND_W-1:0]     mul_a;
  logic [fchc_pkg::MPLIER_W-1:0]    mul_b;
  logic [fchc_pkg::MPLIER_W-1:0]    den;
  fchc_pkg::unit_cmd_t              mul_cmd;
  fchc_pkg::unit_cmd_t              div_cmd;
  fchc_pkg::unit_sts_t              mul_sts;
  fchc_pkg::unit_sts_t              div_sts;
  logic [fchc_pkg::PROD_W-1:0]      product;
  logic [fchc_pkg::QUOT_W-1:0]      quotient;

  logic                             res_apply;
  logic [PW-1:0]                    res_power;
  logic                             res_kick;
  logic                             out_valid;
  logic                             out_apply;
  logic [PW-1:0]                    out_power;
  logic                             out_kick;

  logic [2*fchc_pkg::CFG_DATA_W-1:0] steps_all;
  logic signed [TW-1:0]             pt_temp [NP];
  logic [PW-1:0]                    pt_pct  [NP];
  logic [CW-1:0]                    n_eff;
  logic [SW-1:0]                    last_idx;
  logic [SW-1:0]                    seg;
  logic [SW-1:0]                    seg_nx;
  logic                             lo_case;
  logic                             hi_case;
  logic                             flat;
  logic [PW-1:0]                    direct_pct;
  logic signed [PW:0]               pdiff;
  logic signed [PW:0]               pdiff_abs;
  logic signed [TW:0]               tdiff;
  logic signed [TW:0]               tspan;
  logic signed [BW-1:0]             t_ext;
  logic signed [BW-1:0]             lo_bound;
  logic signed [BW-1:0]             hi_bound;
  logic                             passes;
  logic                             kick;
  logic                             go_interp;
  logic                             load_out;
  logic [PW-1:0]                    sp_sat;
  logic [PW-1:0]                    interp_pct;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_low        <= '0;
      steps_high       <= '0;
      step_count       <= CW'(1);
      hysteresis       <= '0;
      start_power      <= fchc_pkg::PCT_MAX;
      zero_fan_allowed <= 1'b0;
    end else if (cfg_we) begin
      unique case (fchc_pkg::cfg_reg_t'(cfg_index))
        fchc_pkg::REG_STEPS_LOW:   steps_low        <= cfg_data;
        fchc_pkg::REG_STEPS_HIGH:  steps_high       <= cfg_data;
        fchc_pkg::REG_STEP_COUNT:  step_count       <= cfg_data[CW-1:0];
        fchc_pkg::REG_HYSTERESIS:  hysteresis       <= cfg_data[fchc_pkg::HYST_W-1:0];
        fchc_pkg::REG_START_POWER: start_power      <= cfg_data[PW-1:0];
        fchc_pkg::REG_ZERO_FAN:    zero_fan_allowed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign steps_all = {steps_high, steps_low};

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      pt_temp[i] = steps_all[i*fchc_pkg::POINT_W +: TW];
      pt_pct[i]  = fchc_pkg::sat_pct(steps_all[i*fchc_pkg::POINT_W + TW +: 8]);
    end
  end

  always_comb begin
    if (step_count == '0) begin
      n_eff = CW'(1);
    end else if (step_count > CW'(NP)) begin
      n_eff = CW'(NP);
    end else begin
      n_eff = step_count;
    end
    last_idx = SW'(n_eff - CW'(1));

    seg = '0;
    for (int i = 0; i < NP - 1; i++) begin
      if ((CW'(i + 1) < n_eff) && (samp_temp > pt_temp[i])) begin
        seg = SW'(i);
      end
    end
    seg_nx = seg + SW'(1);

    lo_case = (samp_temp <= pt_temp[0]);
    hi_case = (samp_temp > pt_temp[last_idx]);
    flat    = (pt_temp[seg_nx] <= pt_temp[seg]);

    if (lo_case) begin
      direct_pct = pt_pct[0];
    end else if (hi_case) begin
      direct_pct = pt_pct[last_idx];
    end else begin
      direct_pct = pt_pct[seg];
    end

    pdiff     = $signed({1'b0, pt_pct[seg_nx]}) - $signed({1'b0, pt_pct[seg]});
    pdiff_abs = pdiff[PW] ? -pdiff : pdiff;
    tdiff     = {samp_temp[TW-1], samp_temp} - {pt_temp[seg][TW-1], pt_temp[seg]};
    tspan     = {pt_temp[seg_nx][TW-1], pt_temp[seg_nx]} - {pt_temp[seg][TW-1], pt_temp[seg]};

    t_ext    = BW'(samp_temp);
    lo_bound = BW'(last_temp) - $signed({3'b000, hysteresis});
    hi_bound = BW'(last_temp) + $signed({3'b000, hysteresis});
    passes   = !have_last || (t_ext <= lo_bound) || (t_ext >= hi_bound);
    kick     = !zero_fan_allowed && samp_stopped;
    sp_sat   = fchc_pkg::sat_pct({1'b0, start_power});

    go_interp = passes && !kick && !lo_case && !hi_case && !flat;
    load_out  = (state == S_FINISH) && (!out_valid || result.ready);

    interp_pct = neg ? (base - quotient) : (base + quotient);
  end

  fchc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mul_cmd),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .sts     (mul_sts),
    .product (product)
  );

  fchc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .dividend (product),
    .divisor  (den),
    .sts      (div_sts),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      have_last     <= 1'b0;
      last_temp     <= '0;
      out_valid     <= 1'b0;
      mul_cmd.start <= 1'b0;
      div_cmd.start <= 1'b0;
    end else begin
      mul_cmd.start <= (state == S_SETUP) && go_interp;
      div_cmd.start <= (state == S_MUL) && mul_sts.done;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            samp_temp    <= sample.temperature;
            samp_stopped <= sample.fan_stopped;
            state        <= S_SETUP;
          end
        end
        S_SETUP: begin
          res_apply <= passes;
          res_kick  <= passes && kick;
          if (passes) begin
            last_temp <= samp_temp;
            have_last <= 1'b1;
          end
          if (!passes) begin
            res_power <= '0;
            state     <= S_FINISH;
          end else if (kick) begin
            res_power <= sp_sat;
            state     <= S_FINISH;
          end else if (lo_case || hi_case || flat) begin
            res_power <= direct_pct;
            state     <= S_FINISH;
          end else begin
            base  <= pt_pct[seg];
            neg   <= pdiff[PW];
            mul_a <= pdiff_abs[PW-1:0];
            mul_b <= tdiff[TW-1:0];
            den   <= tspan[TW-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_sts.done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            res_power <= interp_pct;
            state     <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load_out) begin
            out_apply <= res_apply;
            out_power <= res_power;
            out_kick  <= res_kick;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample.ready = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.apply = out_apply;
  assign result.power = out_power;
  assign result.kick  = out_kick;

endmodule

`default_nettype wire

// File: sim/fan_curve_hysteresis_controller_test.sv
`timescale 1ns / 100ps

module fan_curve_hysteresis_controller_test;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 100;

  typedef struct packed {
    logic                       apply;
    logic [fchc_pkg::PCT_W-1:0] power;
    logic                       kick;
  } fan_cmd_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t                          kind;
    fchc_pkg::cfg_reg_t                 reg_idx;
    logic [fchc_pkg::CFG_DATA_W-1:0]    value;
    logic signed [fchc_pkg::TEMP_W-1:0] temperature;
    logic                               stopped;
    bit                                 known;
    fan_cmd_t                           result;
  } script_row_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [fchc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fchc_pkg::CFG_DATA_W-1:0] cfg_data;

  fchc_sample_if smp();
  fchc_result_if res();

  fan_curve_hysteresis_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (smp),
    .result    (res)
  );

  // Mirror of the configuration and of the hysteresis state.
  logic [fchc_pkg::CFG_DATA_W-1:0] curve_lo = '0;
  logic [fchc_pkg::CFG_DATA_W-1:0] curve_hi = '0;
  logic [fchc_pkg::STEP_CNT_W-1:0] point_count = 4'd1;
  logic [fchc_pkg::HYST_W-1:0]     hyst_deg = '0;
  logic [fchc_pkg::PCT_W-1:0]      restart_pct = 7'd100;
  logic                            zero_fan_ok = 1'b0;
  int                              last_temp = 0;
  bit                              have_last_temp = 1'b0;

  fan_cmd_t    pending_cmds[$];
  script_row_t directed_rows[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;
  int          span_lo = -128;
  int          span_hi = 127;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[fan_curve_hysteresis_controller] ERROR");
      $finish;
    end
  end

  function automatic logic [fchc_pkg::POINT_W-1:0] point_bits(int idx);
    if (idx < 4) begin
      return curve_lo[(idx % 4) * fchc_pkg::POINT_W +: fchc_pkg::POINT_W];
    end
    return curve_hi[(idx % 4) * fchc_pkg::POINT_W +: fchc_pkg::POINT_W];
  endfunction

  function automatic int point_temp(int idx);
    logic [fchc_pkg::POINT_W-1:0] b;
    b = point_bits(idx);
    return int'($signed(b[7:0]));
  endfunction

  function automatic int point_pct(int idx);
    logic [fchc_pkg::POINT_W-1:0] b;
    int p;
    b = point_bits(idx);
    p = int'(b[15:8]);
    return (p > 100) ? 100 : p;
  endfunction

  function automatic int curve_percent(int t);
    int n;
    int seg;
    int t0;
    int t1;
    int p0;
    int p1;
    n = int'(point_count);
    seg = 0;
    if (n < 1) n = 1;
    if (n > fchc_pkg::NUM_POINTS) n = fchc_pkg::NUM_POINTS;
    if (t <= point_temp(0)) return point_pct(0);
    if (t > point_temp(n - 1)) return point_pct(n - 1);
    for (int i = 0; i + 1 < n; i++) begin
      if (t > point_temp(i)) seg = i;
    end
    t0 = point_temp(seg);
    t1 = point_temp(seg + 1);
    p0 = point_pct(seg);
    p1 = point_pct(seg + 1);
    if (t1 <= t0) return p0;
    return p0 + ((p1 - p0) * (t - t0)) / (t1 - t0);
  endfunction

  function automatic fan_cmd_t predict_command(
      logic signed [fchc_pkg::TEMP_W-1:0] temp_in, logic stopped);
    fan_cmd_t r;
    int t;
    int h;
    int sp;
    int pw;
    bit kick;
    r = '0;
    t = temp_in;
    h = int'(hyst_deg);
    if (!have_last_temp || t <= last_temp - h || t >= last_temp + h) begin
      kick = !zero_fan_ok && stopped;
      sp = (int'(restart_pct) > 100) ? 100 : int'(restart_pct);
      pw = kick ? sp : curve_percent(t);
      r.apply = 1'b1;
      r.power = fchc_pkg::PCT_W'(pw);
      r.kick = kick;
      last_temp = t;
      have_last_temp = 1'b1;
    end
    return r;
  endfunction

  function automatic script_row_t write_row(fchc_pkg::cfg_reg_t idx,
                                            logic [fchc_pkg::CFG_DATA_W-1:0] v);
    script_row_t r;
    r = '{ROW_WRITE, idx, v, '0, 1'b0, 1'b0, '0};
    return r;
  endfunction

  function automatic script_row_t sample_row(int t, logic st);
    script_row_t r;
    r = '{ROW_SAMPLE, fchc_pkg::REG_STEPS_LOW, '0, fchc_pkg::TEMP_W'(t), st, 1'b0, '0};
    return r;
  endfunction

  function automatic script_row_t known_row(int t, logic st, logic a, int p, logic k);
    script_row_t r;
    fan_cmd_t c;
    c.apply = a;
    c.power = fchc_pkg::PCT_W'(p);
    c.kick = k;
    r = '{ROW_SAMPLE, fchc_pkg::REG_STEPS_LOW, '0, fchc_pkg::TEMP_W'(t), st, 1'b1, c};
    return r;
  endfunction

  task automatic send_sample(logic signed [fchc_pkg::TEMP_W-1:0] t, logic st, bit known,
                             fan_cmd_t known_cmd);
    fan_cmd_t e;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    smp.valid <= 1'b1;
    smp.temperature <= t;
    smp.fan_stopped <= st;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    e = predict_command(t, st);
    if (known) e = known_cmd;
    pending_cmds.push_back(e);
  endtask

  task automatic drain;
    @(negedge clk);
    smp.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(fchc_pkg::cfg_reg_t idx,
                               logic [fchc_pkg::CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    unique case (idx)
      fchc_pkg::REG_STEPS_LOW:   curve_lo = v;
      fchc_pkg::REG_STEPS_HIGH:  curve_hi = v;
      fchc_pkg::REG_STEP_COUNT:  point_count = v[fchc_pkg::STEP_CNT_W-1:0];
      fchc_pkg::REG_HYSTERESIS:  hyst_deg = v[fchc_pkg::HYST_W-1:0];
      fchc_pkg::REG_START_POWER: restart_pct = v[fchc_pkg::PCT_W-1:0];
      fchc_pkg::REG_ZERO_FAN:    zero_fan_ok = v[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [fchc_pkg::TEMP_W-1:0] pick_temperature;
    int v;
    int h;
    h = int'(hyst_deg);
    case ($urandom_range(0, 3))
      0, 1: v = span_lo + int'($urandom_range(0, span_hi - span_lo));
      2: v = last_temp + int'($urandom_range(0, 2 * h + 4)) - (h + 2);
      default: v = int'($urandom_range(0, 255)) - 128;
    endcase
    if (v < -128) v = -128;
    if (v > 127) v = 127;
    return fchc_pkg::TEMP_W'(v);
  endfunction

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      res.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = int'($urandom_range(0, 15));
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    fan_cmd_t e;
    if (!rst && res.valid && res.ready) begin
      if (pending_cmds.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result transaction: apply=%0d power=%0d kick=%0d",
                   res.apply, res.power, res.kick);
        end
      end else begin
        e = pending_cmds.pop_front();
        if (res.apply !== e.apply || res.power !== e.power || res.kick !== e.kick) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"result mismatch: expected apply=%0d power=%0d kick=%0d, ",
                      "got apply=%0d power=%0d kick=%0d"},
                     e.apply, e.power, e.kick, res.apply, res.power, res.kick);
          end
        end
      end
    end
  end

  initial begin
    logic [fchc_pkg::CFG_DATA_W-1:0] lo;
    logic [fchc_pkg::CFG_DATA_W-1:0] hi;
    int tcur;
    int pct;
    fan_cmd_t none;
    none = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = fchc_pkg::REG_STEPS_LOW;
    cfg_data = '0;
    smp.valid = 1'b0;
    smp.temperature = '0;
    smp.fan_stopped = 1'b0;
    res.ready = 1'b0;

    // Default curve is a single point at 0 degrees, 0 percent.
    directed_rows.push_back(known_row(-128, 1'b0, 1'b1, 0, 1'b0));
    directed_rows.push_back(known_row(127, 1'b1, 1'b1, 100, 1'b1));
    directed_rows.push_back(known_row(0, 1'b0, 1'b1, 0, 1'b0));
    directed_rows.push_back(known_row(-1, 1'b1, 1'b1, 100, 1'b1));
    // Sorted points with a percent above 100, then an unsorted tail.
    directed_rows.push_back(write_row(fchc_pkg::REG_STEPS_LOW, 64'hC864_503C_3214_0AEC));
    directed_rows.push_back(write_row(fchc_pkg::REG_STEPS_HIGH, 64'h0000_0080_5A7F_FF6E));
    directed_rows.push_back(write_row(fchc_pkg::REG_STEP_COUNT, 64'd0));
    directed_rows.push_back(known_row(127, 1'b0, 1'b1, 10, 1'b0));
    directed_rows.push_back(write_row(fchc_pkg::REG_STEP_COUNT, 64'hF));
    directed_rows.push_back(sample_row(50, 1'b0));
    directed_rows.push_back(sample_row(-20, 1'b0));
    directed_rows.push_back(sample_row(-5, 1'b0));
    directed_rows.push_back(write_row(fchc_pkg::REG_STEP_COUNT, 64'd6));
    directed_rows.push_back(sample_row(0, 1'b0));
    directed_rows.push_back(sample_row(127, 1'b0));
    directed_rows.push_back(sample_row(115, 1'b0));
    directed_rows.push_back(sample_row(-21, 1'b0));
    directed_rows.push_back(sample_row(21, 1'b0));
    directed_rows.push_back(write_row(fchc_pkg::REG_HYSTERESIS, 64'd127));
    directed_rows.push_back(known_row(0, 1'b0, 1'b0, 0, 1'b0));
    directed_rows.push_back(sample_row(-106, 1'b0));
    directed_rows.push_back(known_row(127, 1'b1, 1'b1, 100, 1'b1));
    directed_rows.push_back(write_row(fchc_pkg::REG_HYSTERESIS, 64'd5));
    directed_rows.push_back(write_row(fchc_pkg::REG_START_POWER, 64'd127));
    directed_rows.push_back(known_row(124, 1'b1, 1'b0, 0, 1'b0));
    directed_rows.push_back(known_row(122, 1'b1, 1'b1, 100, 1'b1));
    directed_rows.push_back(write_row(fchc_pkg::REG_START_POWER, 64'd0));
    directed_rows.push_back(write_row(fchc_pkg::REG_ZERO_FAN, 64'd1));
    directed_rows.push_back(sample_row(0, 1'b1));
    directed_rows.push_back(write_row(fchc_pkg::REG_ZERO_FAN, 64'd0));
    directed_rows.push_back(known_row(-128, 1'b1, 1'b1, 0, 1'b1));
    directed_rows.push_back(write_row(fchc_pkg::REG_STEP_COUNT, 64'd2));
    directed_rows.push_back(sample_row(0, 1'b0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain();
        write_setting(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].temperature, directed_rows[i].stopped,
                    directed_rows[i].known, directed_rows[i].result);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      idle_on = (ph < PHASES - 1) && (ph != 4);
      span_lo = -128;
      span_hi = 127;
      if (ph == 0) begin
        write_setting(fchc_pkg::REG_STEPS_LOW, '1);
        write_setting(fchc_pkg::REG_STEPS_HIGH, '1);
        write_setting(fchc_pkg::REG_STEP_COUNT, 64'hF);
        write_setting(fchc_pkg::REG_HYSTERESIS, 64'h7F);
        write_setting(fchc_pkg::REG_START_POWER, 64'h7F);
        write_setting(fchc_pkg::REG_ZERO_FAN, 64'd1);
      end else if (ph == 1) begin
        write_setting(fchc_pkg::REG_STEPS_LOW, '0);
        write_setting(fchc_pkg::REG_STEPS_HIGH, '0);
        write_setting(fchc_pkg::REG_STEP_COUNT, 64'd0);
        write_setting(fchc_pkg::REG_HYSTERESIS, 64'd0);
        write_setting(fchc_pkg::REG_START_POWER, 64'd0);
        write_setting(fchc_pkg::REG_ZERO_FAN, 64'd0);
      end else begin
        if (ph % 4 == 3) begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end else begin
          tcur = int'($urandom_range(0, 180)) - 128;
          span_lo = (tcur - 8 < -128) ? -128 : tcur - 8;
          for (int k = 0; k < fchc_pkg::NUM_POINTS; k++) begin
            pct = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
                                              : int'($urandom_range(0, 100));
            if (k < 4) begin
              lo[k * fchc_pkg::POINT_W +: fchc_pkg::POINT_W] = {8'(pct), 8'(tcur)};
            end else begin
              hi[(k - 4) * fchc_pkg::POINT_W +: fchc_pkg::POINT_W] = {8'(pct), 8'(tcur)};
            end
            tcur = tcur + int'($urandom_range(0, 40));
            if (tcur > 127) tcur = 127;
          end
          span_hi = (tcur + 8 > 127) ? 127 : tcur + 8;
        end
        write_setting(fchc_pkg::REG_STEPS_LOW, lo);
        write_setting(fchc_pkg::REG_STEPS_HIGH, hi);
        write_setting(fchc_pkg::REG_STEP_COUNT,
                      fchc_pkg::CFG_DATA_W'(($urandom_range(0, 4) == 0)
                                            ? $urandom_range(0, 15)
                                            : $urandom_range(2, 8)));
        case ($urandom_range(0, 5))
          0: write_setting(fchc_pkg::REG_HYSTERESIS, 64'd0);
          1: write_setting(fchc_pkg::REG_HYSTERESIS, 64'd127);
          2: write_setting(fchc_pkg::REG_HYSTERESIS,
                           fchc_pkg::CFG_DATA_W'($urandom_range(0, 127)));
          default: write_setting(fchc_pkg::REG_HYSTERESIS,
                                 fchc_pkg::CFG_DATA_W'($urandom_range(1, 8)));
        endcase
        write_setting(fchc_pkg::REG_START_POWER,
                      fchc_pkg::CFG_DATA_W'($urandom_range(0, 127)));
        write_setting(fchc_pkg::REG_ZERO_FAN,
                      fchc_pkg::CFG_DATA_W'($urandom_range(0, 1)));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(pick_temperature(), 1'($urandom_range(0, 1)), 1'b0, none);
      end
    end

    drain();
    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("[fan_curve_hysteresis_controller] OK");
    end else begin
      $display("[fan_curve_hysteresis_controller] ERROR");
    end
    $finish;
  end

endmodule
